/* rtl/hpvt_pkg.sv */
`timescale 1ns / 1ps

package hpvt_pkg;

    localparam int POS_W      = 32;
    localparam int CNT_W      = 8;
    localparam int ACT_W      = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD        = 2'd0,
        ACT_CLEAR_SLOT = 2'd1,
        ACT_CLEAR_ALL  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_WRITE,
        ST_WIPE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] count;
    } entry_t;

    // command from the sequencer to the best tracker
    typedef struct packed {
        logic             clr;
        logic             upd;
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] count;
    } best_cmd_t;

    typedef struct packed {
        logic             held;
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] count;
        logic             tie;
    } best_t;

endpackage

/* rtl/hpvt_if.sv */
`timescale 1ns / 1ps

interface hpvt_in_if;
    logic                      valid;
    logic                      ready;
    logic [hpvt_pkg::ACT_W-1:0] action;
    logic [hpvt_pkg::POS_W-1:0] position;

    modport source (output valid, action, position, input ready);
    modport sink   (input valid, action, position, output ready);
endinterface

interface hpvt_out_if;
    logic                      valid;
    logic                      ready;
    logic                      best_valid;
    logic [hpvt_pkg::POS_W-1:0] best_position;
    logic [hpvt_pkg::CNT_W-1:0] best_count;
    logic                      ambiguous;
    logic                      slot_full;

    modport source (output valid, best_valid, best_position, best_count, ambiguous, slot_full,
                    input ready);
    modport sink   (input valid, best_valid, best_position, best_count, ambiguous, slot_full,
                    output ready);
endinterface

/* rtl/hpvt_ram.sv */
`timescale 1ns / 1ps

module hpvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/hpvt_slot_div.sv */
`timescale 1ns / 1ps

module hpvt_slot_div #(
    parameter int SLOT_COUNT = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [hpvt_pkg::POS_W-1:0]    position,
    output logic                          done,
    output logic [$clog2(SLOT_COUNT)-1:0] slot
);
    import hpvt_pkg::*;

    localparam int  SLOT_W  = $clog2(SLOT_COUNT);
    localparam bit  IS_POW2 = (SLOT_COUNT & (SLOT_COUNT - 1)) == 0;

    logic              done_reg;
    logic [SLOT_W-1:0] slot_reg;

    assign done = done_reg;
    assign slot = slot_reg;

    generate
        if (IS_POW2)
        begin : g_mask
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    slot_reg <= position[SLOT_W-1:0];
                end
            end
        end
        else
        begin : g_recip
            // quotient = (position * RECIP) >> (POS_W + SLOT_W), exact for any 32-bit position
            localparam longint unsigned SCALE = 64'd1 << (POS_W + SLOT_W);
            localparam logic [POS_W:0] RECIP =
                (POS_W+1)'((SCALE + 64'(SLOT_COUNT) - 64'd1) / 64'(SLOT_COUNT));
            localparam logic [SLOT_W-1:0] DIVISOR = SLOT_W'(SLOT_COUNT);

            logic                  busy_reg;
            logic [SLOT_W-1:0]     pos_lo_reg;
            logic [SLOT_W-1:0]     quot_lo_reg;
            logic [2*POS_W:0]      prod;
            logic [SLOT_W-1:0]     back;

            // remainder fits in SLOT_W bits, so only the low bits are carried
            always_comb
            begin
                prod = (2*POS_W+1)'(position) * (2*POS_W+1)'(RECIP);
                back = quot_lo_reg * DIVISOR;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                end
                else
                begin
                    busy_reg <= start;
                    done_reg <= busy_reg;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    pos_lo_reg  <= position[SLOT_W-1:0];
                    quot_lo_reg <= prod[POS_W+SLOT_W +: SLOT_W];
                end
                if (busy_reg)
                begin
                    slot_reg <= pos_lo_reg - back;
                end
            end
        end
    endgenerate

endmodule

/* rtl/hpvt_best.sv */
`timescale 1ns / 1ps

module hpvt_best (
    input  logic                clk,
    input  logic                rst_n,
    input  hpvt_pkg::best_cmd_t cmd,
    output hpvt_pkg::best_t     best
);
    import hpvt_pkg::*;

    best_t best_reg;
    best_t best_next;

    always_comb
    begin
        best_next = best_reg;
        if (cmd.clr)
        begin
            best_next = '0;
        end
        else if (cmd.upd)
        begin
            priority if (!best_reg.held || cmd.count > best_reg.count)
            begin
                best_next.held     = 1'b1;
                best_next.position = cmd.position;
                best_next.count    = cmd.count;
                best_next.tie      = 1'b0;
            end
            else if (cmd.position == best_reg.position)
            begin
                best_next.count = cmd.count;
                best_next.tie   = 1'b0;
            end
            else if (cmd.count == best_reg.count)
            begin
                best_next.tie = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else
        begin
            best_reg <= best_next;
        end
    end

    assign best = best_reg;

endmodule

/* rtl/hashed_position_vote_table_core.sv */
`timescale 1ns / 1ps

// Vote counter for 32-bit positions in a hashed bucket table, tracking the
// best position, its count and a tie flag; one result word per input word.
// Each bucket row (fill count plus ENTRY_DEPTH entries) lives in one wide RAM
// row. The bucket index (position mod SLOT_COUNT) comes from a remainder unit:
// a registered mask when SLOT_COUNT is a power of two, otherwise a reciprocal
// multiply and a multiply-subtract, each registered. An add then scans the
// bucket one entry per cycle with a single comparator, stopping at the
// matching entry or, on a miss, at the fill. An add passes through the
// remainder unit, the scan, the row write and the done state before its result
// is registered; a clear-slot skips the scan, and an unused action code goes
// straight to the done state. Clear-all rewrites every row before its result.
// Ready rises in the same cycle as the result turns valid. After reset the
// block zeroes every table row before it first raises ready. One word is in
// work at a time; the next is taken while a finished result still waits at
// the output.
module hashed_position_vote_table_core #(
    parameter int SLOT_COUNT  = 1024,
    parameter int ENTRY_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    hpvt_in_if.sink     vote,
    hpvt_out_if.source  result
);
    import hpvt_pkg::*;

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int FILL_W = $clog2(ENTRY_DEPTH + 1);

    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(ENTRY_DEPTH);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

    typedef struct packed {
        logic [FILL_W-1:0]               fill;
        entry_t [ENTRY_DEPTH-1:0]        entries;
    } row_t;

    state_t             state_reg, state_next;
    logic [ACT_W-1:0]   act_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [FILL_W-1:0]  idx_reg;
    logic               hit_reg;
    logic               dropped_reg;
    logic [SLOT_W-1:0]  clr_cnt_reg;

    logic               out_valid_reg;
    best_t              out_best_reg;
    logic               out_full_reg;

    logic               div_start;
    logic               div_done;
    logic [SLOT_W-1:0]  div_slot;

    row_t               row_rd;
    row_t               row_wr;
    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr;
    row_t               ram_wdata;

    entry_t             sel;
    logic               match;
    logic               drop;
    logic [CNT_W-1:0]   vote_cnt;
    logic               accept;
    logic               out_load;
    logic               sweep_last;

    best_cmd_t          best_cmd;
    best_t              best;

    hpvt_slot_div #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .position (vote.position),
        .done     (div_done),
        .slot     (div_slot)
    );

    hpvt_ram #(
        .WIDTH ($bits(row_t)),
        .DEPTH (SLOT_COUNT)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (div_slot),
        .rdata (row_rd)
    );

    hpvt_best u_best (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (best_cmd),
        .best  (best)
    );

    // shared comparator: entry under the scan index against the voted position
    always_comb
    begin
        sel = '0;
        for (int e = 0; e < ENTRY_DEPTH; e++)
        begin
            if (idx_reg == FILL_W'(e))
            begin
                sel = row_rd.entries[e];
            end
        end
        match = (idx_reg != row_rd.fill) && (sel.position == pos_reg);
        drop  = !hit_reg && (row_rd.fill >= FILL_MAX);
    end

    // updated row for write-back
    always_comb
    begin
        row_wr   = row_rd;
        vote_cnt = (sel.count == CNT_MAX) ? sel.count : sel.count + 1'b1;
        if (act_reg == ACT_CLEAR_SLOT)
        begin
            row_wr.fill = '0;
        end
        else if (hit_reg)
        begin
            for (int e = 0; e < ENTRY_DEPTH; e++)
            begin
                if (idx_reg == FILL_W'(e))
                begin
                    row_wr.entries[e].count = vote_cnt;
                end
            end
        end
        else
        begin
            vote_cnt = CNT_W'(1);
            for (int e = 0; e < ENTRY_DEPTH; e++)
            begin
                if (row_rd.fill == FILL_W'(e))
                begin
                    row_wr.entries[e].position = pos_reg;
                    row_wr.entries[e].count    = CNT_W'(1);
                end
            end
            row_wr.fill = row_rd.fill + 1'b1;
        end
    end

    assign sweep_last = (clr_cnt_reg == SLOT_LAST);
    assign accept     = vote.valid && vote.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (vote.valid)
                begin
                    unique case (vote.action)
                        ACT_ADD, ACT_CLEAR_SLOT: state_next = ST_DIV;
                        ACT_CLEAR_ALL:           state_next = ST_WIPE;
                        default:                 state_next = ST_DONE;
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = (act_reg == ACT_ADD) ? ST_SCAN : ST_WRITE;
                end
            end
            ST_SCAN:
            begin
                if (match || idx_reg == row_rd.fill)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_DONE;
            end
            ST_WIPE:
            begin
                if (sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        vote.ready = (state_reg == ST_IDLE);
        div_start  = accept && (vote.action == ACT_ADD || vote.action == ACT_CLEAR_SLOT);
        out_load   = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

        ram_we    = 1'b0;
        ram_waddr = div_slot;
        ram_wdata = row_wr;
        if (state_reg == ST_INIT || state_reg == ST_WIPE)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else if (state_reg == ST_WRITE)
        begin
            ram_we = !(act_reg == ACT_ADD && drop);
        end

        best_cmd.clr      = accept && (vote.action == ACT_CLEAR_ALL);
        best_cmd.upd      = (state_reg == ST_WRITE) && (act_reg == ACT_ADD) && !drop;
        best_cmd.position = pos_reg;
        best_cmd.count    = vote_cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_INIT || state_reg == ST_WIPE)
            begin
                clr_cnt_reg <= sweep_last ? '0 : clr_cnt_reg + 1'b1;
            end

            if (accept)
            begin
                idx_reg     <= '0;
                hit_reg     <= 1'b0;
                dropped_reg <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                hit_reg <= match;
                if (!match && idx_reg != row_rd.fill)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            else if (state_reg == ST_WRITE)
            begin
                dropped_reg <= (act_reg == ACT_ADD) && drop;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= vote.action;
            pos_reg <= vote.position;
        end
        if (out_load)
        begin
            out_best_reg <= best;
            out_full_reg <= dropped_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.best_valid    = out_best_reg.held;
    assign result.best_position = out_best_reg.position;
    assign result.best_count    = out_best_reg.count;
    assign result.ambiguous     = out_best_reg.tie;
    assign result.slot_full     = out_full_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !vote.ready)
        else $error("input taken again right after accept");

    a_held_count: assert property (@(posedge clk) disable iff (!rst_n)
        best.held == (best.count != '0))
        else $error("best held flag disagrees with best count");

    a_tie_needs_best: assert property (@(posedge clk) disable iff (!rst_n)
        best.tie |-> best.held)
        else $error("tie flagged with no best held");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE && ram_we) |-> (row_wr.fill <= FILL_MAX))
        else $error("bucket fill written past entry depth");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import hpvt_pkg::*;

    localparam int SLOT_COUNT   = 1024;
    localparam int ENTRY_DEPTH  = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 120;
    localparam int HOT_SLOTS    = 4;
    localparam int HOT_PER_SLOT = 12;   // more than ENTRY_DEPTH so hot buckets overflow
    localparam int MAX_PRINTS   = 40;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        best_t best;
        logic  slot_full;
    } tally_word_t;

    class vote_table_tracker;
        int          fill [SLOT_COUNT];
        logic [31:0] ent_pos [SLOT_COUNT][ENTRY_DEPTH];
        logic [7:0]  ent_cnt [SLOT_COUNT][ENTRY_DEPTH];
        best_t       leader;
        tally_word_t pending [$];
        int          errors;

        function new();
            foreach (fill[i])
            begin
                fill[i] = 0;
            end
            leader = '0;
            errors = 0;
        endfunction

        // returns 1 when the vote is dropped on a full bucket
        function bit tally(logic [31:0] pos);
            int         slot;
            int         n;
            int         hit;
            logic [7:0] c;
            slot = int'(pos % SLOT_COUNT);
            n    = fill[slot];
            hit  = -1;
            for (int i = 0; i < n; i++)
            begin
                if (hit < 0 && ent_pos[slot][i] == pos)
                    hit = i;
            end
            if (hit >= 0)
            begin
                if (ent_cnt[slot][hit] != CNT_MAX)
                    ent_cnt[slot][hit] = ent_cnt[slot][hit] + 8'd1;
                c = ent_cnt[slot][hit];
            end
            else
            begin
                if (n >= ENTRY_DEPTH)
                    return 1'b1;
                ent_pos[slot][n] = pos;
                ent_cnt[slot][n] = 8'd1;
                fill[slot]       = n + 1;
                c                = 8'd1;
            end
            if (!leader.held)
            begin
                leader.held     = 1'b1;
                leader.position = pos;
                leader.count    = c;
                leader.tie      = 1'b0;
            end
            else if (pos == leader.position)
            begin
                leader.count = c;
                leader.tie   = 1'b0;
            end
            else if (c == leader.count)
                leader.tie = 1'b1;
            else if (c > leader.count)
            begin
                leader.position = pos;
                leader.count    = c;
                leader.tie      = 1'b0;
            end
            return 1'b0;
        endfunction

        function void note_vote(logic [ACT_W-1:0] act, logic [31:0] pos);
            tally_word_t w;
            logic        dropped;
            dropped = 1'b0;
            case (act)
                ACT_ADD:        dropped = tally(pos);
                ACT_CLEAR_SLOT: fill[int'(pos % SLOT_COUNT)] = 0;
                ACT_CLEAR_ALL:
                begin
                    foreach (fill[i])
                    begin
                        fill[i] = 0;
                    end
                    leader = '0;
                end
                default: ;
            endcase
            w.best      = leader;
            w.slot_full = dropped;
            pending.push_back(w);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("[%0t] %s mismatch: got %h, expected %h", $time, what, got, want);
        endtask

        task check_result(tally_word_t got);
            tally_word_t want;
            if (pending.size() == 0)
            begin
                report("unrequested word", got.best.position, 32'h0);
                return;
            end
            want = pending.pop_front();
            if (got.best.held !== want.best.held)
                report("best_valid", got.best.held, want.best.held);
            if (got.best.position !== want.best.position)
                report("best_position", got.best.position, want.best.position);
            if (got.best.count !== want.best.count)
                report("best_count", got.best.count, want.best.count);
            if (got.best.tie !== want.best.tie)
                report("ambiguous", got.best.tie, want.best.tie);
            if (got.slot_full !== want.slot_full)
                report("slot_full", got.slot_full, want.slot_full);
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   burst_left;
    vote_table_tracker tracker;

    hpvt_in_if  vote_if ();
    hpvt_out_if res_if ();

    hashed_position_vote_table_core #(
        .SLOT_COUNT  (SLOT_COUNT),
        .ENTRY_DEPTH (ENTRY_DEPTH)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .vote   (vote_if),
        .result (res_if)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: rotates through four stall styles (always ready, coin flip, one in four, periodic stall)
    always @(negedge clk)
    begin
        case ((cycle_count / 97) % 4)
            0:       res_if.ready <= 1'b1;
            1:       res_if.ready <= 1'($urandom_range(0, 1));
            2:       res_if.ready <= ($urandom_range(0, 3) == 0);
            default: res_if.ready <= (cycle_count % 5 != 4);
        endcase
    end

    always @(posedge clk)
    begin
        tally_word_t got;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got.best.held     = res_if.best_valid;
            got.best.position = res_if.best_position;
            got.best.count    = res_if.best_count;
            got.best.tie      = res_if.ambiguous;
            got.slot_full     = res_if.slot_full;
            tracker.check_result(got);
        end
    end

    // called at a falling edge, returns at a falling edge
    task send_word(logic [ACT_W-1:0] act, logic [31:0] pos);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                vote_if.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        vote_if.valid    = 1'b1;
        vote_if.action   = act;
        vote_if.position = pos;
        do
            @(posedge clk);
        while (!vote_if.ready);
        tracker.note_vote(act, pos);
        @(negedge clk);
    endtask

    task wait_drained();
        vote_if.valid = 1'b0;
        while (tracker.pending.size() != 0)
            @(negedge clk);
    endtask

    function logic [31:0] in_slot(int slot, int k);
        return 32'(k) * SLOT_COUNT + 32'(slot);
    endfunction

    initial
    begin
        logic [31:0] hot_pos [HOT_SLOTS*HOT_PER_SLOT];
        logic [31:0] pos;
        int          slot;
        int          r;
        int          clear_alls;

        tracker          = new();
        cycle_count      = 0;
        burst_left       = 0;
        clear_alls       = 0;
        rst_n            = 1'b0;
        vote_if.valid    = 1'b0;
        vote_if.action   = ACT_ADD;
        vote_if.position = '0;
        res_if.ready     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ties, leader changes, full bucket, cleared best, unused code
        send_word(ACT_ADD, 32'h0000_0000);
        send_word(ACT_ADD, 32'hFFFF_FFFF);
        send_word(ACT_ADD, 32'h0000_0000);
        send_word(ACT_ADD, 32'hFFFF_FFFF);
        send_word(ACT_ADD, 32'hFFFF_FFFF);
        for (int k = 0; k < ENTRY_DEPTH; k++)
            send_word(ACT_ADD, in_slot(37, k));
        send_word(ACT_ADD, in_slot(37, ENTRY_DEPTH));
        send_word(ACT_ADD, in_slot(37, 3));
        send_word(ACT_CLEAR_SLOT, 32'hFFFF_FFFF);
        send_word(ACT_ADD, 32'hFFFF_FFFF);
        send_word(ACT_ADD, 32'h0000_0000);
        send_word(ACT_UNUSED, 32'h0000_5555);
        send_word(ACT_CLEAR_SLOT, in_slot(37, 9));
        send_word(ACT_ADD, in_slot(37, ENTRY_DEPTH));
        send_word(ACT_CLEAR_ALL, 32'h0000_0000);
        send_word(ACT_ADD, 32'hAAAA_AAAA);
        send_word(ACT_ADD, 32'h5555_5555);
        send_word(ACT_UNUSED, 32'hFFFF_FFFF);
        wait_drained();

        // drive one position past the count ceiling
        for (int i = 0; i < 260; i++)
            send_word(ACT_ADD, 32'h8000_0123);

        for (int s = 0; s < HOT_SLOTS; s++)
        begin
            slot = $urandom_range(0, SLOT_COUNT - 1);
            for (int k = 0; k < HOT_PER_SLOT; k++)
                hot_pos[s*HOT_PER_SLOT + k] = in_slot(slot, $urandom_range(0, 22'h3F_FFFF));
        end

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS / 2)
                wait_drained();
            // six favorites in the first hot slot get a large share of votes so leaders and ties form
            if ($urandom_range(0, 9) < 4)
                pos = hot_pos[$urandom_range(0, 5)];
            else
                pos = hot_pos[$urandom_range(0, HOT_SLOTS*HOT_PER_SLOT - 1)];
            r = $urandom_range(0, 99);
            if (r < 72)
                send_word(ACT_ADD, pos);
            else if (r < 84)
                send_word(ACT_ADD, $urandom);
            else if (r < 93)
                send_word(ACT_CLEAR_SLOT, pos);
            else if (r < 97)
                send_word(ACT_UNUSED, $urandom);
            else if (clear_alls < 5)
            begin
                clear_alls++;
                send_word(ACT_CLEAR_ALL, $urandom);
            end
            else
                send_word(ACT_ADD, pos);
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (tracker.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
